>>> design/pbaw_pkg.sv
package pbaw_pkg;

	localparam int DATA_W    = 32;
	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MODE       = 3'd0,
		CFG_GAIN_PROP  = 3'd1,
		CFG_GAIN_INTEG = 3'd2,
		CFG_GAIN_DERIV = 3'd3,
		CFG_OUT_UPPER  = 3'd4,
		CFG_OUT_LOWER  = 3'd5
	} cfg_reg_t;

	typedef enum logic [1:0] {
		MODE_P   = 2'd0,
		MODE_PI  = 2'd1,
		MODE_PID = 2'd2
	} mode_t;

	localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

endpackage

>>> design/pid_backcalc_antiwindup.sv
// PID controller with back-calculation anti-windup, signed fixed point with
// FRAC_BITS fraction bits on all 32-bit values.
//
// Input channel: in_valid / in_stall carry one error_sample per transaction.
// Output channel: out_valid / out_stall carry drive and limited per
// transaction; exactly one result leaves for every sample taken.
// Config channel: cfg_valid / cfg_ready write cfg_data into register
// cfg_index (0 mode, 1..3 gains, 4 upper clamp, 5 lower clamp); cfg_ready is
// always high and writes to other indexes are dropped. Write only while idle.
//
// Pipeline: a taken sample sits in the input register, and its result is
// loaded into the output register as it advances and shown on the ports.
// Throughput: one sample per cycle unless out_stall holds a waiting result;
// the integrator and last-error loop closes as each sample advances.
// When out_stall holds a waiting result, one more sample is still taken into
// the input register; after that in_stall rises until the output drains.
// Reset: mode full PID, gains zero, clamps at the full 32-bit range,
// integrator and last error zero, both pipeline stages empty.
module pid_backcalc_antiwindup
	import pbaw_pkg::*;
#(
	parameter int FRAC_BITS   = 16,
	parameter int INTEG_WIDTH = 48
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic signed [DATA_W-1:0] error_sample,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [DATA_W-1:0] drive,
	output logic                     limited,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [DATA_W-1:0]        cfg_data
);

	localparam int PROD_W  = 2 * DATA_W;
	localparam int DIFF_W  = DATA_W + 1;
	localparam int DPROD_W = DIFF_W + DATA_W;
	localparam int TERM_W  = DPROD_W + 1 - FRAC_BITS;
	localparam int SUM_W   = ((INTEG_WIDTH > TERM_W) ? INTEG_WIDTH : TERM_W) + 2;

	logic [1:0]                      mode_q;
	logic signed [DATA_W-1:0]        gain_prop_q, gain_integ_q, gain_deriv_q;
	logic signed [DATA_W-1:0]        out_upper_q, out_lower_q;
	logic signed [INTEG_WIDTH-1:0]   integ_q;
	logic signed [DATA_W-1:0]        prev_err_q;

	logic                            vld_s1;
	logic signed [DATA_W-1:0]        err_s1;
	logic                            vld_s2;
	logic signed [DATA_W-1:0]        drive_s2;
	logic                            limited_s2;

	logic                            advance;
	logic                            use_i, use_d;
	logic signed [PROD_W-1:0]        p_full, ie_full;
	logic signed [DIFF_W-1:0]        diff;
	logic signed [DPROD_W-1:0]       d_full;
	logic signed [SUM_W-1:0]         p_ext, ie_ext, d_ext, pd, integ_ext, pre;
	logic signed [SUM_W-1:0]         upper_ext, lower_ext, clamped, next_full;
	logic                            hit_upper, hit_lower, clamp_hit;
	logic signed [INTEG_WIDTH-1:0]   integ_next;
	logic                            integ_fits;

	assign cfg_ready = 1'b1;
	assign advance   = vld_s1 && (!vld_s2 || !out_stall);
	assign in_stall  = vld_s1 && !advance;
	assign out_valid = vld_s2;
	assign drive     = drive_s2;
	assign limited   = limited_s2;

	assign use_i = mode_q != MODE_P;
	assign use_d = (mode_q != MODE_P) && (mode_q != MODE_PI);

	always_comb begin
		p_full  = PROD_W'(err_s1) * PROD_W'(gain_prop_q);
		ie_full = PROD_W'(err_s1) * PROD_W'(gain_integ_q);
		diff    = DIFF_W'(err_s1) - DIFF_W'(prev_err_q);
		d_full  = DPROD_W'(diff) * DPROD_W'(gain_deriv_q);

		// exact product, then floor shift
		p_ext  = SUM_W'(p_full >>> FRAC_BITS);
		ie_ext = SUM_W'(ie_full >>> FRAC_BITS);
		d_ext  = use_d ? SUM_W'(d_full >>> FRAC_BITS) : '0;
		pd     = p_ext + d_ext;

		integ_ext = SUM_W'(integ_q);
		pre       = use_i ? pd + integ_ext : pd;

		upper_ext = SUM_W'(out_upper_q);
		lower_ext = SUM_W'(out_lower_q);
		// upper test wins when the clamps are crossed
		hit_upper = pre > upper_ext;
		hit_lower = !hit_upper && (pre < lower_ext);
		clamp_hit = hit_upper || hit_lower;
		clamped   = hit_upper ? upper_ext : (hit_lower ? lower_ext : pre);

		// back-calculation: integ + ie + (clamped - pre)
		next_full  = clamp_hit ? clamped + ie_ext - pd : integ_ext + ie_ext;
		integ_fits = (next_full[SUM_W-1:INTEG_WIDTH-1] == '0)
			|| (next_full[SUM_W-1:INTEG_WIDTH-1] == '1);
		if (integ_fits)
			integ_next = next_full[INTEG_WIDTH-1:0];
		else if (next_full[SUM_W-1])
			integ_next = {1'b1, {(INTEG_WIDTH-1){1'b0}}};
		else
			integ_next = {1'b0, {(INTEG_WIDTH-1){1'b1}}};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_PID;
			gain_prop_q  <= '0;
			gain_integ_q <= '0;
			gain_deriv_q <= '0;
			out_upper_q  <= DATA_MAX;
			out_lower_q  <= DATA_MIN;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				CFG_MODE:       mode_q       <= cfg_data[1:0];
				CFG_GAIN_PROP:  gain_prop_q  <= cfg_data;
				CFG_GAIN_INTEG: gain_integ_q <= cfg_data;
				CFG_GAIN_DERIV: gain_deriv_q <= cfg_data;
				CFG_OUT_UPPER:  out_upper_q  <= cfg_data;
				CFG_OUT_LOWER:  out_lower_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			vld_s1 <= 1'b1;
		end else if (advance) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall)
			err_s1 <= error_sample;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (advance) begin
			vld_s2 <= 1'b1;
		end else if (!out_stall) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			drive_s2   <= clamped[DATA_W-1:0];
			limited_s2 <= clamp_hit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q    <= '0;
			prev_err_q <= '0;
		end else if (advance) begin
			if (use_i)
				integ_q <= integ_next;
			if (use_d)
				prev_err_q <= err_s1;
		end
	end

	// a clamped result carries one of the clamp values
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && limited |-> (drive == out_upper_q) || (drive == out_lower_q))
		else $error("limited result is not at a clamp");

	// an unclamped result lies inside both clamps
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !limited |-> (drive <= out_upper_q) && (drive >= out_lower_q))
		else $error("unclamped result outside the clamp range");

	// controller state moves only with a sample that goes through
	assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(integ_q) && $stable(prev_err_q))
		else $error("controller state changed without a sample");

	// proportional form leaves the integrator alone
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && (mode_q == MODE_P) |=> $stable(integ_q) && $stable(prev_err_q))
		else $error("state changed in proportional form");

	// the input side only stalls when the input register is occupied
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> vld_s1 && vld_s2 && out_stall)
		else $error("input stalled with room downstream");

endmodule

>>> tb/sv/pid_backcalc_antiwindup_tb.sv
module pid_backcalc_antiwindup_tb;
	import pbaw_pkg::*;

	localparam int          FRAC      = 16;
	localparam int          INTEG_W   = 48;
	localparam int          LIMIT     = 400000;
	localparam logic [1:0]  MODE_ALT  = 2'd3;   // unused code, behaves as full PID
	localparam logic signed [31:0] ONE = 32'sh0001_0000;

	typedef logic signed [127:0] wide_t;
	typedef struct packed {
		logic signed [31:0] drive;
		logic               limited;
	} drive_res_t;

	localparam wide_t INTEG_HI = (wide_t'(1) <<< (INTEG_W - 1)) - 1;
	localparam wide_t INTEG_LO = -INTEG_HI - 1;

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_stall;
	logic signed [DATA_W-1:0] error_sample;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic signed [DATA_W-1:0] drive;
	logic                     limited;
	logic                     cfg_valid;
	logic                     cfg_ready;
	logic [CFG_IDX_W-1:0]     cfg_index;
	logic [DATA_W-1:0]        cfg_data;

	// controller shadow: configuration and state
	logic [1:0]         sh_mode  = MODE_PID;
	logic signed [31:0] sh_kp    = '0;
	logic signed [31:0] sh_ki    = '0;
	logic signed [31:0] sh_kd    = '0;
	logic signed [31:0] sh_upper = DATA_MAX;
	logic signed [31:0] sh_lower = DATA_MIN;
	logic signed [INTEG_W-1:0] sh_integ    = '0;
	logic signed [31:0]        sh_last_err = '0;

	drive_res_t pending_drives[$];

	int  cycle;
	int  errors;
	int  n_samples;
	int  n_results;
	int  n_limited;
	int  n_settings;
	bit  tx_jitter;
	bit  rx_jitter;
	logic hold_rx;

	pid_backcalc_antiwindup dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.error_sample (error_sample),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.drive        (drive),
		.limited      (limited),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle++;
		if (cycle > LIMIT) begin
			$display("Timeout after %0d cycles", cycle);
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic wide_t q_mul(wide_t a, wide_t b);
		wide_t prod;
		prod = a * b;
		return prod >>> FRAC;
	endfunction

	// advance the controller by one error sample
	function automatic drive_res_t pid_advance(logic signed [31:0] err);
		wide_t      e, p, d, pd, pre, outv, ie, nxt;
		logic       use_i, use_d, lim;
		drive_res_t r;
		use_i = (sh_mode != MODE_P);
		use_d = (sh_mode >= MODE_PID);
		e     = wide_t'(err);
		p     = q_mul(e, wide_t'(sh_kp));
		d     = use_d ? q_mul(e - wide_t'(sh_last_err), wide_t'(sh_kd)) : wide_t'(0);
		pd    = p + d;
		pre   = use_i ? pd + wide_t'(sh_integ) : pd;
		outv  = pre;
		lim   = 1'b0;
		if (pre > wide_t'(sh_upper)) begin
			outv = wide_t'(sh_upper);
			lim  = 1'b1;
		end else if (pre < wide_t'(sh_lower)) begin
			outv = wide_t'(sh_lower);
			lim  = 1'b1;
		end
		if (use_i) begin
			ie  = q_mul(e, wide_t'(sh_ki));
			nxt = lim ? outv + ie - pd : wide_t'(sh_integ) + ie;
			if (nxt > INTEG_HI)
				nxt = INTEG_HI;
			else if (nxt < INTEG_LO)
				nxt = INTEG_LO;
			sh_integ = nxt[INTEG_W-1:0];
		end
		if (use_d)
			sh_last_err = err;
		r.drive   = outv[31:0];
		r.limited = lim;
		return r;
	endfunction

	task automatic log_error(input string msg);
		errors++;
		if (errors <= 10)
			$display("ERROR cycle %0d: %s", cycle, msg);
	endtask

	// track accepted samples and register writes
	always @(posedge clk) begin
		if (arst_n && cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_MODE:       sh_mode  = cfg_data[1:0];
				CFG_GAIN_PROP:  sh_kp    = cfg_data;
				CFG_GAIN_INTEG: sh_ki    = cfg_data;
				CFG_GAIN_DERIV: sh_kd    = cfg_data;
				CFG_OUT_UPPER:  sh_upper = cfg_data;
				CFG_OUT_LOWER:  sh_lower = cfg_data;
				default: ;
			endcase
		end
		if (arst_n && in_valid && !in_stall) begin
			pending_drives.push_back(pid_advance(error_sample));
			n_samples++;
		end
	end

	// check each result transaction against the oldest prediction
	always @(posedge clk) begin
		drive_res_t want;
		if (arst_n && out_valid && !out_stall) begin
			n_results++;
			if (limited)
				n_limited++;
			if (pending_drives.size() == 0) begin
				log_error($sformatf("unexpected result drive=%0d limited=%0b",
					drive, limited));
			end else begin
				want = pending_drives.pop_front();
				if (drive !== want.drive)
					log_error($sformatf("drive: expected %0d, got %0d",
						want.drive, drive));
				if (limited !== want.limited)
					log_error($sformatf("limited: expected %0b, got %0b",
						want.limited, limited));
			end
		end
	end

	always @(posedge clk)
		out_stall <= hold_rx || (rx_jitter && $urandom_range(0, 99) < 24);

	task automatic send_error(input logic signed [31:0] e);
		while (tx_jitter && $urandom_range(0, 99) < 24) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		error_sample <= e;
		do @(posedge clk); while (in_stall);
	endtask

	// drop valid and hold until every result is back
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_drives.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic set_config(input logic [1:0] m, input logic signed [31:0] kp,
		input logic signed [31:0] ki, input logic signed [31:0] kd,
		input logic signed [31:0] hi, input logic signed [31:0] lo);
		write_reg(CFG_MODE, {30'b0, m});
		write_reg(CFG_GAIN_PROP, kp);
		write_reg(CFG_GAIN_INTEG, ki);
		write_reg(CFG_GAIN_DERIV, kd);
		write_reg(CFG_OUT_UPPER, hi);
		write_reg(CFG_OUT_LOWER, lo);
		cfg_valid <= 1'b0;
		@(posedge clk);
		n_settings++;
	endtask

	function automatic logic signed [31:0] rand_error();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return $urandom_range(0, 1 << 21) - (1 << 20);
		else if (r < 85)
			return $urandom;
		case ($urandom_range(0, 4))
			0:       return DATA_MAX;
			1:       return DATA_MIN;
			2:       return -1;
			3:       return 1;
			default: return 0;
		endcase
	endfunction

	function automatic logic signed [31:0] tame_gain();
		return $urandom_range(0, 1 << 19) - (1 << 18);
	endfunction

	task automatic test_reset_defaults();
		// zero gains after reset: drive stays at zero
		send_error(ONE);
		send_error(-ONE);
		wait_idle();
	endtask

	task automatic test_field_extremes();
		set_config(MODE_PID, ONE, ONE >>> 1, ONE >>> 2, DATA_MAX, DATA_MIN);
		send_error(DATA_MAX);
		send_error(DATA_MIN);
		send_error(0);
		send_error(-1);
		send_error(1);
		wait_idle();
	endtask

	task automatic test_modes();
		logic [1:0] modes[4];
		modes = '{MODE_P, MODE_PI, MODE_PID, MODE_ALT};
		foreach (modes[i]) begin
			set_config(modes[i], 32'sh1_8000, 32'sh4000, 32'sh2_0000,
				32'sh0010_0000, -32'sh0010_0000);
			send_error(32'sh3_0000);
			send_error(-32'sh1_2345);
			wait_idle();
		end
	endtask

	task automatic test_clamps();
		set_config(MODE_PID, 2 * ONE, ONE, 0, 32'sh5_0000, -32'sh5_0000);
		send_error(32'sh4_0000);
		send_error(-32'sh4_0000);
		wait_idle();
		// crossed limits: upper test wins
		set_config(MODE_PID, 2 * ONE, ONE, 0, -32'sh1_0000, 32'sh1_0000);
		send_error(0);
		send_error(32'sh2_0000);
		wait_idle();
	endtask

	task automatic test_integ_saturation();
		set_config(MODE_PID, DATA_MIN, DATA_MAX, DATA_MIN, DATA_MAX, DATA_MIN);
		send_error(DATA_MIN);
		send_error(DATA_MAX);
		send_error(DATA_MAX);
		wait_idle();
		set_config(MODE_PI, 0, DATA_MIN, DATA_MAX, DATA_MAX, DATA_MIN);
		send_error(DATA_MAX);
		send_error(DATA_MAX);
		send_error(DATA_MIN);
		wait_idle();
	endtask

	task automatic test_backpressure();
		set_config(MODE_PID, tame_gain(), tame_gain(), tame_gain(),
			32'sh0100_0000, -32'sh0100_0000);
		fork
			begin
				hold_rx <= 1'b1;
				repeat (80) @(posedge clk);
				hold_rx <= 1'b0;
			end
			repeat (30) send_error(rand_error());
		join
		wait_idle();
	endtask

	task automatic test_random();
		logic [1:0]         m;
		logic signed [31:0] kp, ki, kd, hi, lo;
		for (int ph = 0; ph < 12; ph++) begin
			m  = 2'($urandom_range(0, 3));
			kp = tame_gain();
			ki = tame_gain();
			kd = tame_gain();
			hi = $urandom_range(1 << 16, 1 << 26);
			lo = -$urandom_range(1 << 16, 1 << 26);
			case (ph % 4)
				1: begin
					kp = $urandom;
					ki = $urandom;
					kd = $urandom;
					hi = $urandom;
					lo = $urandom;
				end
				2: begin
					hi = DATA_MAX;
					lo = DATA_MIN;
				end
				3: begin
					lo = $urandom_range(0, 1 << 24) - (1 << 23);
					hi = lo - $urandom_range(0, 1 << 20);
				end
				default: ;
			endcase
			set_config(m, kp, ki, kd, hi, lo);
			// one long stretch with both sides streaming
			tx_jitter = (ph != 5);
			rx_jitter = (ph != 5);
			repeat (125) send_error(rand_error());
			wait_idle();
		end
		tx_jitter = 1'b1;
		rx_jitter = 1'b1;
	endtask

	initial begin
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		error_sample = '0;
		cfg_valid    = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		hold_rx      = 1'b0;
		tx_jitter    = 1'b1;
		rx_jitter    = 1'b1;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_field_extremes();
		test_modes();
		test_clamps();
		test_integ_saturation();
		test_backpressure();
		test_random();

		wait_idle();
		repeat (8) @(posedge clk);
		if (pending_drives.size() != 0)
			log_error($sformatf("%0d results never arrived", pending_drives.size()));
		$display("Ran %0d error samples over %0d controller settings (all modes, crossed",
			n_samples, n_settings);
		$display("and full-range limits); %0d of %0d drive outputs were limited",
			n_limited, n_results);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

>>> pid_backcalc_antiwindup.f
design/pbaw_pkg.sv
design/pid_backcalc_antiwindup.sv
tb/sv/pid_backcalc_antiwindup_tb.sv
